/* design/cau_pkg.sv */
// Package: types, constants and helper functions of the complex arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

   localparam int WORD_BITS         = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int TOL_BITS          = 8;
   localparam int WIDE_BITS         = 2 * WORD_BITS + 2;

   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_NEG = 3'd4;
   localparam logic [2:0] FUNC_CMP = 3'd5;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SAT  = 2'd1;
   localparam logic [1:0] STATUS_DIV0 = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] MAG_POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] MAG_NEG_MAX = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic [2:0] func;
      word_type   a_re;
      word_type   a_im;
      word_type   b_re;
      word_type   b_im;
   } req_type;

   typedef struct packed {
      word_type   r_re;
      word_type   r_im;
      logic [1:0] status;
      logic       is_equal;
   } rsp_type;

   typedef struct packed {
      logic                          is_mul;
      logic                          is_div;
      logic signed [2*WORD_BITS-1:0] p_rr;
      logic signed [2*WORD_BITS-1:0] p_ii;
      logic signed [2*WORD_BITS-1:0] p_ri;
      logic signed [2*WORD_BITS-1:0] p_ir;
      logic [2*WORD_BITS-1:0]        p_br2;
      logic [2*WORD_BITS-1:0]        p_bi2;
      rsp_type                       res;
   } prod_type;

   typedef struct packed {
      logic                   neg;
      logic                   ovf;
      logic [2*WORD_BITS-1:0] rem;
      logic [WORD_BITS-1:0]   num_lo;
      logic [WORD_BITS-1:0]   quo;
   } lane_type;

   typedef struct packed {
      rsp_type                res;
      logic                   is_div;
      logic [2*WORD_BITS-1:0] den;
      lane_type               re;
      lane_type               im;
   } div_type;

   typedef struct packed {
      word_type value;
      logic     sat;
   } sat_type;

   function automatic sat_type saturate(input logic signed [WIDE_BITS-1:0] v);
      sat_type                       r;
      logic [WIDE_BITS-WORD_BITS:0]  top;
      top = v[WIDE_BITS-1:WORD_BITS-1];
      if ((top == '0) || (top == '1)) begin
         r.value = v[WORD_BITS-1:0];
         r.sat   = 1'b0;
      end else begin
         r.value = v[WIDE_BITS-1] ? WORD_MIN : WORD_MAX;
         r.sat   = 1'b1;
      end
      return r;
   endfunction

   function automatic sat_type finish_lane(input lane_type l);
      sat_type r;
      r.sat   = 1'b0;
      r.value = l.quo;
      if (l.ovf) begin
         r.sat   = 1'b1;
         r.value = l.neg ? WORD_MIN : WORD_MAX;
      end else if (l.neg) begin
         if (l.quo > MAG_NEG_MAX) begin
            r.sat   = 1'b1;
            r.value = WORD_MIN;
         end else begin
            r.value = '0 - l.quo;
         end
      end else if (l.quo > MAG_POS_MAX) begin
         r.sat   = 1'b1;
         r.value = WORD_MAX;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/cau_front.sv */
// First stage: partial products and the add, subtract, negate and compare results
`timescale 1ns / 1ps
`default_nettype none
module cau_front
   import cau_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire req_type             in_data,
   input  wire logic [TOL_BITS-1:0] tol,
   output logic                     out_valid,
   output prod_type                 out_data
);

   logic     valid_ff;
   prod_type data_ff;
   prod_type data_in;

   logic signed [WORD_BITS:0] sum_re, sum_im, dif_re, dif_im, neg_re, neg_im;
   logic [WORD_BITS:0]        mag_re, mag_im;
   sat_type                   s_re, s_im;
   logic                      b_zero;

   always_comb begin
      sum_re = (WORD_BITS+1)'(in_data.a_re) + (WORD_BITS+1)'(in_data.b_re);
      sum_im = (WORD_BITS+1)'(in_data.a_im) + (WORD_BITS+1)'(in_data.b_im);
      dif_re = (WORD_BITS+1)'(in_data.a_re) - (WORD_BITS+1)'(in_data.b_re);
      dif_im = (WORD_BITS+1)'(in_data.a_im) - (WORD_BITS+1)'(in_data.b_im);
      neg_re = '0 - (WORD_BITS+1)'(in_data.a_re);
      neg_im = '0 - (WORD_BITS+1)'(in_data.a_im);
      mag_re = dif_re[WORD_BITS] ? (WORD_BITS+1)'(-dif_re) : dif_re;
      mag_im = dif_im[WORD_BITS] ? (WORD_BITS+1)'(-dif_im) : dif_im;
      b_zero = (in_data.b_re == '0) && (in_data.b_im == '0);
      s_re   = '0;
      s_im   = '0;

      data_in.p_rr  = in_data.a_re * in_data.b_re;
      data_in.p_ii  = in_data.a_im * in_data.b_im;
      data_in.p_ri  = in_data.a_re * in_data.b_im;
      data_in.p_ir  = in_data.a_im * in_data.b_re;
      data_in.p_br2 = in_data.b_re * in_data.b_re;
      data_in.p_bi2 = in_data.b_im * in_data.b_im;
      data_in.is_mul = 1'b0;
      data_in.is_div = 1'b0;
      data_in.res    = '0;

      case (in_data.func)
         FUNC_ADD: begin
            s_re = saturate(WIDE_BITS'(sum_re));
            s_im = saturate(WIDE_BITS'(sum_im));
         end
         FUNC_SUB: begin
            s_re = saturate(WIDE_BITS'(dif_re));
            s_im = saturate(WIDE_BITS'(dif_im));
         end
         FUNC_NEG: begin
            s_re = saturate(WIDE_BITS'(neg_re));
            s_im = saturate(WIDE_BITS'(neg_im));
         end
         FUNC_CMP: begin
            data_in.res.is_equal = (mag_re <= (WORD_BITS+1)'(tol)) &&
                                   (mag_im <= (WORD_BITS+1)'(tol));
         end
         FUNC_MUL: begin
            data_in.is_mul = 1'b1;
         end
         FUNC_DIV: begin
            if (b_zero) begin
               data_in.res.status = STATUS_DIV0;
            end else begin
               data_in.is_div = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if ((in_data.func == FUNC_ADD) || (in_data.func == FUNC_SUB) ||
          (in_data.func == FUNC_NEG)) begin
         data_in.res.r_re   = s_re.value;
         data_in.res.r_im   = s_im.value;
         data_in.res.status = (s_re.sat || s_im.sat) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* design/cau_combine.sv */
// Second stage: product sums, multiply result and divider setup
`timescale 1ns / 1ps
`default_nettype none
module cau_combine
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire prod_type in_data,
   output logic          out_valid,
   output div_type       out_data
);

   localparam int NUM_BITS = 2 * WORD_BITS + 1 + FRAC_BITS;
   localparam int TOP_BITS = NUM_BITS - WORD_BITS;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   logic signed [2*WORD_BITS:0] m_re, m_im, n_re, n_im;
   sat_type                     s_re, s_im;

   function automatic lane_type lane_init(input logic signed [2*WORD_BITS:0] n,
                                          input logic [2*WORD_BITS-1:0] d);
      lane_type            l;
      logic [2*WORD_BITS:0] mag;
      logic [NUM_BITS-1:0]  sh;
      logic [TOP_BITS-1:0]  top;
      mag      = n[2*WORD_BITS] ? (2*WORD_BITS+1)'(-n) : n;
      sh       = NUM_BITS'(mag) << FRAC_BITS;
      top      = sh[NUM_BITS-1:WORD_BITS];
      l.neg    = n[2*WORD_BITS];
      l.ovf    = NUM_BITS'(top) >= NUM_BITS'(d);
      l.rem    = (2*WORD_BITS)'(top);
      l.num_lo = sh[WORD_BITS-1:0];
      l.quo    = '0;
      return l;
   endfunction

   always_comb begin
      m_re = (2*WORD_BITS+1)'(in_data.p_rr) - (2*WORD_BITS+1)'(in_data.p_ii);
      m_im = (2*WORD_BITS+1)'(in_data.p_ri) + (2*WORD_BITS+1)'(in_data.p_ir);
      n_re = (2*WORD_BITS+1)'(in_data.p_rr) + (2*WORD_BITS+1)'(in_data.p_ii);
      n_im = (2*WORD_BITS+1)'(in_data.p_ir) - (2*WORD_BITS+1)'(in_data.p_ri);
      s_re = saturate(WIDE_BITS'(m_re >>> FRAC_BITS));
      s_im = saturate(WIDE_BITS'(m_im >>> FRAC_BITS));

      data_in.den    = in_data.p_br2 + in_data.p_bi2;
      data_in.is_div = in_data.is_div;
      data_in.re     = lane_init(n_re, data_in.den);
      data_in.im     = lane_init(n_im, data_in.den);
      data_in.res    = in_data.res;
      if (in_data.is_mul) begin
         data_in.res.r_re   = s_re.value;
         data_in.res.r_im   = s_im.value;
         data_in.res.status = (s_re.sat || s_im.sat) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* design/cau_div_step.sv */
// Divider stage: one restoring quotient bit for the real and imaginary lanes
`timescale 1ns / 1ps
`default_nettype none
module cau_div_step
   import cau_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire logic    in_valid,
   input  wire div_type in_data,
   output logic         out_valid,
   output div_type      out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   function automatic lane_type lane_step(input lane_type l,
                                          input logic [2*WORD_BITS-1:0] d);
      lane_type             r;
      logic [2*WORD_BITS:0] r2;
      logic [2*WORD_BITS:0] diff;
      logic                 ge;
      r2       = {l.rem, l.num_lo[WORD_BITS-1]};
      diff     = r2 - {1'b0, d};
      ge       = r2 >= {1'b0, d};
      r        = l;
      r.rem    = ge ? diff[2*WORD_BITS-1:0] : r2[2*WORD_BITS-1:0];
      r.num_lo = l.num_lo << 1;
      r.quo    = {l.quo[WORD_BITS-2:0], ge};
      return r;
   endfunction

   always_comb begin
      data_in    = in_data;
      data_in.re = lane_step(in_data.re, in_data.den);
      data_in.im = lane_step(in_data.im, in_data.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

/* design/complex_arithmetic_unit.sv */
// Top level: pipelined complex add, subtract, multiply, divide, negate and compare
//
//   channel  ports                     direction  carries
//   req      req_valid/req_ready/req   in         func and operands a, b
//   rsp      rsp_valid/rsp_ready/rsp   out        result, status, is_equal
//   csr      csr_we/csr_wdata          in         equal_tolerance write
//
// A request passes the front and combine stages, the divider steps and the rsp
// register; the divider yields one quotient bit per stage for both lanes at once.
// One transfer per cycle unless rsp stalls; every op runs the full pipeline.
// Reset clears all valid bits and the tolerance register.
// A stalled rsp freezes the whole pipeline; req_ready drops in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_type             req,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_type                  rsp,
   input  wire logic                csr_we,
   input  wire logic [TOL_BITS-1:0] csr_wdata
);

   logic [TOL_BITS-1:0] tol_ff;
   logic                en;
   logic                front_valid;
   prod_type            front_data;
   logic                stage_valid [0:WORD_BITS];
   div_type             stage_data  [0:WORD_BITS];
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   sat_type             fin_re, fin_im;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req),
      .tol       (tol_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   cau_combine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_combine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   for (genvar k = 0; k < WORD_BITS; k++) begin : g_div
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   always_comb begin
      fin_re = finish_lane(stage_data[WORD_BITS].re);
      fin_im = finish_lane(stage_data[WORD_BITS].im);
      rsp_in = stage_data[WORD_BITS].res;
      if (stage_data[WORD_BITS].is_div) begin
         rsp_in.r_re     = fin_re.value;
         rsp_in.r_im     = fin_im.value;
         rsp_in.status   = (fin_re.sat || fin_im.sat) ? STATUS_SAT : STATUS_OK;
         rsp_in.is_equal = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= stage_valid[WORD_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

/* design/cau_checker.sv */
// Checker: port-level properties of the complex arithmetic unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
module cau_checker
   import cau_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("stalled rsp transfer changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req_ready low with free output");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == STATUS_DIV0) |->
         (rsp.r_re == '0) && (rsp.r_im == '0) && !rsp.is_equal)
      else $error("divide by zero result not cleared");

   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.is_equal |->
         (rsp.r_re == '0) && (rsp.r_im == '0) && (rsp.status == STATUS_OK))
      else $error("compare result carries data");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
`default_nettype wire

/* dv/tb.sv */
// Testbench for the complex arithmetic unit: random and directed operations checked by a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import cau_pkg::*;

   class cau_scoreboard;
      rsp_type    pending_q[$];
      logic [7:0] tol;
      int         errors;

      function new();
         tol    = '0;
         errors = 0;
      endfunction

      function automatic logic signed [WORD_BITS-1:0] clamp(input logic signed [127:0] v,
                                                            inout logic sat);
         if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return WORD_MAX;
         end
         if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return WORD_MIN;
         end
         return v[WORD_BITS-1:0];
      endfunction

      function automatic logic signed [127:0] quot(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
         logic signed [127:0] m;
         m = (n < 0) ? -n : n;
         m = m / d;
         return (n < 0) ? -m : m;
      endfunction

      function void note_request(input req_type r);
         rsp_type             e;
         logic                sat;
         logic signed [127:0] ar, ai, br, bi, s, dr, di;
         ar = r.a_re;  ai = r.a_im;  br = r.b_re;  bi = r.b_im;
         e = '0;
         sat = 1'b0;
         case (r.func)
            FUNC_ADD: begin
               e.r_re = clamp(ar + br, sat);
               e.r_im = clamp(ai + bi, sat);
            end
            FUNC_SUB: begin
               e.r_re = clamp(ar - br, sat);
               e.r_im = clamp(ai - bi, sat);
            end
            FUNC_MUL: begin
               e.r_re = clamp((ar * br - ai * bi) >>> 16, sat);
               e.r_im = clamp((ar * bi + ai * br) >>> 16, sat);
            end
            FUNC_DIV: begin
               if (br == 0 && bi == 0) e.status = STATUS_DIV0;
               else begin
                  s = br * br + bi * bi;
                  e.r_re = clamp(quot((ar * br + ai * bi) <<< 16, s), sat);
                  e.r_im = clamp(quot((ai * br - ar * bi) <<< 16, s), sat);
               end
            end
            FUNC_NEG: begin
               e.r_re = clamp(-ar, sat);
               e.r_im = clamp(-ai, sat);
            end
            FUNC_CMP: begin
               dr = ar - br;  di = ai - bi;
               if (dr < 0) dr = -dr;
               if (di < 0) di = -di;
               e.is_equal = (dr <= tol) && (di <= tol);
            end
            default: ;
         endcase
         if (e.status == STATUS_OK && sat) e.status = STATUS_SAT;
         pending_q.push_back(e);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.r_re !== e.r_re) begin
            $display("%0t: r_re expected %h actual %h", $time, e.r_re, got.r_re);
            errors++;
         end
         if (got.r_im !== e.r_im) begin
            $display("%0t: r_im expected %h actual %h", $time, e.r_im, got.r_im);
            errors++;
         end
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.is_equal !== e.is_equal) begin
            $display("%0t: is_equal expected %0d actual %0d", $time, e.is_equal,
                     got.is_equal);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp;
   logic       csr_we = 1'b0;
   logic [7:0] csr_wdata = '0;

   cau_scoreboard sb = new();
   int  send_idle = 0;
   int  recv_idle = 0;
   int  hold_off  = 0;

   complex_arithmetic_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp);
   end

   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   function automatic word_type pick_word();
      case ($urandom_range(7))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return word_type'($urandom_range(255)) - 128;
         4: return word_type'(int'($urandom_range(65535 * 4)) - 131072);
         default: return word_type'($urandom());
      endcase
   endfunction

   task automatic send(input req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r.func = 3'($urandom_range(7));
         if ($urandom_range(15) != 0 && r.func > FUNC_CMP) r.func = 3'($urandom_range(5));
         r.a_re = pick_word();
         r.a_im = pick_word();
         r.b_re = pick_word();
         r.b_im = $urandom_range(3) == 0 ? '0 : pick_word();
         if (r.func == FUNC_CMP && $urandom_range(1)) begin
            r.b_re = r.a_re + word_type'(int'($urandom_range(600)) - 300);
            r.b_im = r.a_im + word_type'(int'($urandom_range(600)) - 300);
         end
         send(r);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_tol(input logic [7:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.tol = v;
   endtask

   task automatic directed();
      req_type r;
      for (int f = 0; f < 8; f++) begin
         r = '{3'(f), WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX};
         send(r);
      end
      send('{FUNC_DIV, 32'sh10000, 32'sh20000, '0, '0});
      send('{FUNC_DIV, 32'sh30000, 32'sh10000, 32'sh10000, 32'sh10000});
      send('{FUNC_DIV, WORD_MAX, WORD_MAX, 32'sd1, '0});
      send('{FUNC_NEG, WORD_MIN, WORD_MIN, '0, '0});
      send('{FUNC_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN});
      send('{FUNC_MUL, 32'sh18000, -32'sh8000, 32'sh20000, '0});
      send('{FUNC_ADD, 32'sh10000, '0, 32'sh28000, '0});
      send('{FUNC_SUB, '0, '0, WORD_MIN, WORD_MAX});
      send('{FUNC_CMP, 32'sd100, 32'sd5, 32'sd100, 32'sd5});
      send('{FUNC_CMP, 32'sd100, 32'sd5, 32'sd103, 32'sd2});
      send('{FUNC_CMP, WORD_MAX, '0, WORD_MIN, '0});
      send('{FUNC_DIV, -32'sh10000, '0, '0, 32'sd1});
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      drain();
      write_tol(8'd3);
      directed();
      drain();
      write_tol(8'd255);
      send_idle = 13;
      recv_idle = 65;
      send_random(600);
      drain();
      write_tol(8'($urandom_range(255)));
      send_idle = 65;
      recv_idle = 13;
      send_random(600);
      drain();
      write_tol(8'd0);
      send_idle = 0;
      recv_idle = 0;
      hold_off  = 120;
      send_random(650);
      drain();
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
